### hdl/spit_pkg.sv
package spit_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CROSS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TOUCH = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NEAR = 2'd3;

  localparam int OUT_W = 8;

endpackage

### hdl/segment_pair_intersect_tolerant_unit.sv
// Throughput: one item per cycle unless m_axis_tready stalls the output; eight register
// stages, each holding one item, with the wide squared products cut into half-width
// partial products.
// Each stage advances when its successor is empty or advancing, so bubbles collapse.
// Reset (rst, synchronous, active high) empties every stage and sets tolerance to 1.
module segment_pair_intersect_tolerant_unit #(
  parameter int COORD_WIDTH = spit_pkg::COORD_W_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [spit_pkg::TOL_W-1:0]            cfg_wdata,     // tolerance
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // a_start_x, a_start_y, a_stop_x, a_stop_y, a_error_bound,
  // b_start_x, b_start_y, b_stop_x, b_stop_y, b_error_bound, zero pad
  input  logic [((10*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [spit_pkg::OUT_W-1:0]            m_axis_tdata   // hit, hit_kind, zero pad
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = spit_pkg::TOL_W;
  localparam int D  = CW + 1;       // coordinate difference width
  localparam int M  = 2 * D;        // magnitude of a product or of a sum of squares
  localparam int C  = 2 * D + 1;    // signed two-product sum
  localparam int W  = 4 * D;        // squared compare width
  localparam int QP = 2 * TW + D;   // tolerance partial product width
  localparam int BOFS = 5 * CW - 1; // start of second segment in tdata
  localparam int NJ = 14;           // two-product jobs
  localparam int NS = 8;            // pipeline stages

  // tolerance register; to be written only while the pipe is empty, which the block does not enforce
  logic [TW-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= spit_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [NS:1] vld;
  logic [NS:1] en;

  always_comb begin
    en[NS] = !vld[NS] || m_axis_tready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_axis_tvalid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: capture
  logic signed [CW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
  logic [CW-2:0] aerr, berr;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      asx  <= s_axis_tdata[0*CW +: CW];
      asy  <= s_axis_tdata[1*CW +: CW];
      aex  <= s_axis_tdata[2*CW +: CW];
      aey  <= s_axis_tdata[3*CW +: CW];
      aerr <= s_axis_tdata[4*CW +: CW-1];
      bsx  <= s_axis_tdata[BOFS + 0*CW +: CW];
      bsy  <= s_axis_tdata[BOFS + 1*CW +: CW];
      bex  <= s_axis_tdata[BOFS + 2*CW +: CW];
      bey  <= s_axis_tdata[BOFS + 3*CW +: CW];
      berr <= s_axis_tdata[BOFS + 4*CW +: CW-1];
    end
  end

  // ---------------------------------------------------------------- stage 2: differences
  // Point inside the box of a segment widened by the tolerance.
  function automatic logic inbox(input logic signed [CW-1:0] px, py, bx, by, ex, ey,
                                 input logic [TW-1:0] e);
    logic signed [CW+1:0] lx, hx, ly, hy, ee, qx, qy;
    ee = (CW+2)'($signed({1'b0, e}));
    lx = (CW+2)'((bx < ex) ? bx : ex);
    hx = (CW+2)'((bx < ex) ? ex : bx);
    ly = (CW+2)'((by < ey) ? by : ey);
    hy = (CW+2)'((by < ey) ? ey : by);
    qx = (CW+2)'(px);
    qy = (CW+2)'(py);
    return (qx >= lx - ee) && (qx <= hx + ee) && (qy >= ly - ee) && (qy <= hy + ee);
  endfunction

  logic signed [D-1:0] adx, ady, bdx, bdy, u1x, u1y, u2x, u2y, u3x, u3y, u4x, u4y;
  logic signed [D-1:0] v14x, v14y, v24x, v24y;
  logic signed [D-1:0] ja_x [NJ], ja_y [NJ], jb_x [NJ], jb_y [NJ];
  logic signed [D-1:0] oa_x [NJ], oa_y [NJ], ob_x [NJ], ob_y [NJ];
  logic [3:0] box_c;
  logic [3:0] box2, box3, box4, box5, box6, box7;
  logic [D-1:0] rad, rad2;

  always_comb begin
    adx  = D'(aex) - D'(asx);
    ady  = D'(aey) - D'(asy);
    bdx  = D'(bex) - D'(bsx);
    bdy  = D'(bey) - D'(bsy);
    u1x  = D'(bsx) - D'(asx);
    u1y  = D'(bsy) - D'(asy);
    u2x  = D'(bex) - D'(asx);
    u2y  = D'(bey) - D'(asy);
    u3x  = D'(asx) - D'(bsx);
    u3y  = D'(asy) - D'(bsy);
    u4x  = D'(aex) - D'(bsx);
    u4y  = D'(aey) - D'(bsy);
    v14x = D'(asx) - D'(bex);
    v14y = D'(asy) - D'(bey);
    v24x = D'(aex) - D'(bex);
    v24y = D'(aey) - D'(bey);
    // crosses against each segment's direction (jobs 0 to 3)
    ja_x[0] = adx;  ja_y[0] = ady;  jb_x[0] = u1x;  jb_y[0] = u1y;
    ja_x[1] = adx;  ja_y[1] = ady;  jb_x[1] = u2x;  jb_y[1] = u2y;
    ja_x[2] = bdx;  ja_y[2] = bdy;  jb_x[2] = u3x;  jb_y[2] = u3y;
    ja_x[3] = bdx;  ja_y[3] = bdy;  jb_x[3] = u4x;  jb_y[3] = u4y;
    // squared lengths
    ja_x[4] = adx;  ja_y[4] = ady;  jb_x[4] = adx;  jb_y[4] = ady;
    ja_x[5] = bdx;  ja_y[5] = bdy;  jb_x[5] = bdx;  jb_y[5] = bdy;
    // squared endpoint distances
    ja_x[6] = u3x;  ja_y[6] = u3y;  jb_x[6] = u3x;  jb_y[6] = u3y;
    ja_x[7] = v14x; ja_y[7] = v14y; jb_x[7] = v14x; jb_y[7] = v14y;
    ja_x[8] = u4x;  ja_y[8] = u4y;  jb_x[8] = u4x;  jb_y[8] = u4y;
    ja_x[9] = v24x; ja_y[9] = v24y; jb_x[9] = v24x; jb_y[9] = v24y;
    // projections of each endpoint onto the other segment
    ja_x[10] = u3x; ja_y[10] = u3y; jb_x[10] = bdx; jb_y[10] = bdy;
    ja_x[11] = u4x; ja_y[11] = u4y; jb_x[11] = bdx; jb_y[11] = bdy;
    ja_x[12] = u1x; ja_y[12] = u1y; jb_x[12] = adx; jb_y[12] = ady;
    ja_x[13] = u2x; ja_y[13] = u2y; jb_x[13] = adx; jb_y[13] = ady;
    box_c[0] = inbox(bsx, bsy, asx, asy, aex, aey, tol);
    box_c[1] = inbox(bex, bey, asx, asy, aex, aey, tol);
    box_c[2] = inbox(asx, asy, bsx, bsy, bex, bey, tol);
    box_c[3] = inbox(aex, aey, bsx, bsy, bex, bey, tol);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      oa_x <= ja_x;
      oa_y <= ja_y;
      ob_x <= jb_x;
      ob_y <= jb_y;
      box2 <= box_c;
      rad  <= D'(aerr) + D'(berr) + D'(tol);
    end
  end

  // ---------------------------------------------------------------- stage 3: products
  logic signed [M-1:0] m0 [NJ], m1 [NJ];
  logic [M-1:0] r2_3, r2_4, r2_5;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NJ; i++) begin
        if (i < 4) begin
          m0[i] <= oa_x[i] * ob_y[i];
          m1[i] <= oa_y[i] * ob_x[i];
        end else begin
          m0[i] <= oa_x[i] * ob_x[i];
          m1[i] <= oa_y[i] * ob_y[i];
        end
      end
      r2_3 <= M'(rad) * M'(rad);
      box3 <= box2;
    end
  end

  assign rad2 = rad;

  // ---------------------------------------------------------------- stage 4: sums
  logic signed [C-1:0] sm [NJ];
  logic [2*TW-1:0] e2_4, e2_5;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < NJ; i++) begin
        if (i < 4) begin
          sm[i] <= C'(m0[i]) - C'(m1[i]);
        end else begin
          sm[i] <= C'(m0[i]) + C'(m1[i]);
        end
      end
      e2_4 <= (2*TW)'(tol) * (2*TW)'(tol);
      r2_4 <= r2_3;
      box4 <= box3;
    end
  end

  // ---------------------------------------------------------------- stage 5: magnitudes, cases
  logic signed [C-1:0] cabs [4];
  logic [M-1:0] mag_c [4];
  logic [3:0] neg_c;
  logic [M-1:0] la, lb, mxa_c, mxb_c;
  logic [M-1:0] wd [4], fd [4], ln [4];
  logic signed [C-1:0] kk [4];
  logic [3:0] dir_c, res_c;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      neg_c[j] = sm[j][C-1];
      cabs[j]  = neg_c[j] ? -sm[j] : sm[j];
      mag_c[j] = cabs[j][M-1:0];
    end
    la    = sm[4][M-1:0];
    lb    = sm[5][M-1:0];
    mxa_c = (la > M'(e2_4)) ? la : M'(e2_4);
    mxb_c = (lb > M'(e2_4)) ? lb : M'(e2_4);
    // endpoint tests: start of A and stop of A against B, then B's ends against A
    wd[0] = sm[6][M-1:0]; fd[0] = sm[7][M-1:0]; kk[0] = sm[10]; ln[0] = lb;
    wd[1] = sm[8][M-1:0]; fd[1] = sm[9][M-1:0]; kk[1] = sm[11]; ln[1] = lb;
    wd[2] = sm[6][M-1:0]; fd[2] = sm[8][M-1:0]; kk[2] = sm[12]; ln[2] = la;
    wd[3] = sm[7][M-1:0]; fd[3] = sm[9][M-1:0]; kk[3] = sm[13]; ln[3] = la;
    for (int n = 0; n < 4; n++) begin
      // projection at or before the start, or at or beyond the stop, clamps to that endpoint
      if (kk[n][C-1] || kk[n] == '0) begin
        dir_c[n] = 1'b1;
        res_c[n] = wd[n] <= r2_4;
      end else if (kk[n] >= $signed({1'b0, ln[n]})) begin
        dir_c[n] = 1'b1;
        res_c[n] = fd[n] <= r2_4;
      end else begin
        dir_c[n] = 1'b0;
        res_c[n] = 1'b0;
      end
    end
  end

  logic [M-1:0] mag [4];
  logic [3:0] neg5, neg6, neg7;
  logic [M-1:0] mxa, mxb, la5, lb5;
  logic [3:0] dir5, dir6, dir7, res5, res6, res7;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mag  <= mag_c;
      neg5 <= neg_c;
      mxa  <= mxa_c;
      mxb  <= mxb_c;
      la5  <= la;
      lb5  <= lb;
      e2_5 <= e2_4;
      r2_5 <= r2_4;
      dir5 <= dir_c;
      res5 <= res_c;
      box5 <= box4;
    end
  end

  // ---------------------------------------------------------------- stage 6: partial products
  logic [M-1:0] ph [4], pm [4], pl [4];
  logic [QP-1:0] qh [2], ql [2];
  logic [M-1:0] rhh [2], rhl [2], rlh [2], rll [2];
  logic [M-1:0] lsel [2];
  logic [M-1:0] msel [2];

  always_comb begin
    lsel[0] = la5;
    lsel[1] = lb5;
    msel[0] = mxa;
    msel[1] = mxb;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int j = 0; j < 4; j++) begin
        ph[j] <= M'(mag[j][M-1:D]) * M'(mag[j][M-1:D]);
        pm[j] <= M'(mag[j][M-1:D]) * M'(mag[j][D-1:0]);
        pl[j] <= M'(mag[j][D-1:0]) * M'(mag[j][D-1:0]);
      end
      for (int s = 0; s < 2; s++) begin
        qh[s]  <= QP'(e2_5) * QP'(msel[s][M-1:D]);
        ql[s]  <= QP'(e2_5) * QP'(msel[s][D-1:0]);
        rhh[s] <= M'(r2_5[M-1:D]) * M'(lsel[s][M-1:D]);
        rhl[s] <= M'(r2_5[M-1:D]) * M'(lsel[s][D-1:0]);
        rlh[s] <= M'(r2_5[D-1:0]) * M'(lsel[s][M-1:D]);
        rll[s] <= M'(r2_5[D-1:0]) * M'(lsel[s][D-1:0]);
      end
      neg6 <= neg5;
      dir6 <= dir5;
      res6 <= res5;
      box6 <= box5;
    end
  end

  // ---------------------------------------------------------------- stage 7: wide sums
  logic [W-1:0] csq [4], qq [2], rl [2];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int j = 0; j < 4; j++) begin
        csq[j] <= (W'(ph[j]) << (2*D)) + (W'(pm[j]) << (D+1)) + W'(pl[j]);
      end
      for (int s = 0; s < 2; s++) begin
        qq[s] <= (W'(qh[s]) << D) + W'(ql[s]);
        rl[s] <= (W'(rhh[s]) << (2*D)) + ((W'(rhl[s]) + W'(rlh[s])) << D) + W'(rll[s]);
      end
      neg7 <= neg6;
      dir7 <= dir6;
      res7 <= res6;
      box7 <= box6;
    end
  end

  // ---------------------------------------------------------------- stage 8: decide
  logic [3:0] nz;
  logic [3:0] nr;
  logic proper, touch, close;
  logic [spit_pkg::KIND_W-1:0] kind_c, kind;

  always_comb begin
    nz[0] = csq[0] > qq[0];
    nz[1] = csq[1] > qq[0];
    nz[2] = csq[2] > qq[1];
    nz[3] = csq[3] > qq[1];
    // cross against the other segment: A's ends use cross 2 and 3, B's ends 0 and 1
    nr[0] = dir7[0] ? res7[0] : (csq[2] <= rl[1]);
    nr[1] = dir7[1] ? res7[1] : (csq[3] <= rl[1]);
    nr[2] = dir7[2] ? res7[2] : (csq[0] <= rl[0]);
    nr[3] = dir7[3] ? res7[3] : (csq[1] <= rl[0]);
    proper = nz[0] && nz[1] && (neg7[0] ^ neg7[1])
          && nz[2] && nz[3] && (neg7[2] ^ neg7[3]);
    touch  = |(~nz & box7);
    close  = |nr;
    priority if (proper) begin
      kind_c = spit_pkg::KIND_CROSS;
    end else if (touch) begin
      kind_c = spit_pkg::KIND_TOUCH;
    end else if (close) begin
      kind_c = spit_pkg::KIND_NEAR;
    end else begin
      kind_c = spit_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      kind <= kind_c;
    end
  end

  assign m_axis_tdata = {{(spit_pkg::OUT_W-1-spit_pkg::KIND_W){1'b0}}, kind,
                         kind != spit_pkg::KIND_NONE};

  // ---------------------------------------------------------------- checks
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld) && !m_axis_tready)
    else $error("input stalled with a free stage");

  a_hit_matches_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != spit_pkg::KIND_NONE)))
    else $error("hit disagrees with hit_kind");

  a_tol_reset: assert property (@(posedge clk)
    rst |=> (tol == spit_pkg::TOL_RESET))
    else $error("tolerance not restored by reset");

  a_fill_one_step: assert property (@(posedge clk) disable iff (rst)
    (!vld[1] && !$past(rst)) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("accepted item lost at first stage");

  a_rad_stable: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && !en[3]) |=> $stable(rad2))
    else $error("stalled radius changed");

endmodule
